### hdl/label_centroid_accumulator_unit_defines.svh
// ----------------------------------------------------------------------------
// Label centroid accumulator: assertion macros
// Shared concurrent assertion forms used by the RTL modules of the block.
// ----------------------------------------------------------------------------
`ifndef LABEL_CENTROID_ACCUMULATOR_UNIT_DEFINES_SVH
`define LABEL_CENTROID_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lcacc_pkg.sv
// ----------------------------------------------------------------------------
// Label centroid accumulator package
// Field widths, default sizes, accumulator entry layout and divider status.
// ----------------------------------------------------------------------------
package lcacc_pkg;

    // default sizes
    localparam int MAX_CLUSTERS_DEF = 64;
    localparam int MAX_DIM_DEF      = 4096;

    // word field widths
    localparam int LABEL_W = 7;
    localparam int COORD_W = 12;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;

    // configuration register
    localparam int               CFG_MAX   = 127;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // accumulator widths
    localparam int CNT_W  = 25;
    localparam int SUM_W  = 36;
    localparam int ACC_W  = CNT_W + 2 * SUM_W;

    // divider: quotient bits equal the coordinate width, one bit per cycle
    localparam int QUO_W     = COORD_W;
    localparam int DIV_SHIFT = QUO_W - 1;
    localparam int STEP_W    = $clog2(QUO_W);

    // one accumulator entry as stored in the RAM
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
    } acc_entry_t;

    // divider status toward the readout sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } div_res_t;

endpackage

### hdl/label_centroid_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Label centroid accumulator
// Per-cluster pixel count and coordinate sums in one RAM; centroid readout.
// ----------------------------------------------------------------------------
// Pixels are taken at one per cycle while in_ready is high: the cluster
// entry is read from the accumulator RAM at acceptance and written back in
// the following cycle, with the write forwarded when the next pixel hits the
// same cluster. The word marked last_pixel stops input; after its update
// lands, the sequencer walks all MAX_CLUSTERS entries, clearing each. An
// entry not in use passes through ST_READ and ST_LOOK, an empty cluster
// through ST_READ, ST_LOOK and ST_EMIT plus the output handshake, and a
// filled cluster also through ST_DIV, where the 12-step shared divider runs.
// After reset the block clears the RAM in ST_CLEAR before it accepts pixels.
module label_centroid_accumulator_unit #(
    parameter int MAX_CLUSTERS = lcacc_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_DIM      = lcacc_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lcacc_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lcacc_pkg::LABEL_W-1:0] label,
    input  logic [lcacc_pkg::COORD_W-1:0]        x_pos,
    input  logic [lcacc_pkg::COORD_W-1:0]        y_pos,
    input  logic                                 last_pixel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lcacc_pkg::IDX_W-1:0]          cluster_index,
    output logic [lcacc_pkg::COORD_W-1:0]        center_x,
    output logic [lcacc_pkg::COORD_W-1:0]        center_y,
    output logic                                 empty_res,
    output logic                                 last
);

    import lcacc_pkg::*;
    `include "label_centroid_accumulator_unit_defines.svh"

    localparam int AW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CAP   = (MAX_CLUSTERS > CFG_MAX) ? CFG_MAX : MAX_CLUSTERS;
    localparam int LA_W  = (AW > IDX_W) ? AW : IDX_W;
    localparam int CMP_W = (AW > CFG_W) ? AW : CFG_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CRD_W = (DIM_W > COORD_W) ? DIM_W : COORD_W;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_RUN   = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_LOOK  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CFG_W-1:0] cluster_count_reg;

    // update stage
    logic             s1_vld_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic             fwd_hit_reg;
    acc_entry_t       fwd_data_reg;

    // output word
    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    logic [IDX_W-1:0] cluster_index_reg;
    logic [COORD_W-1:0] center_x_reg, center_y_reg;
    logic             empty_res_reg, last_reg;
    logic [COORD_W-1:0] load_x, load_y;
    logic             load_empty;

    // RAM ports
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    acc_entry_t       wr_data, rd_data;

    logic             accept;
    logic [CFG_W-1:0] used;
    logic             pix_ok;
    logic [LA_W-1:0]  lab_ext, idx_ext;
    logic [AW-1:0]    pix_addr;
    logic [CMP_W-1:0] idx_cmp;
    logic             in_use, is_last_used, idx_last;

    acc_entry_t       old_ent, new_ent;
    logic [CNT_W:0]   cnt_sum;
    logic [SUM_W:0]   sx_sum, sy_sum;
    logic             acc_wr, clr_wr;

    logic             div_start;
    div_res_t         div_res;

    // clusters in use and pixel qualification
    assign used     = (cluster_count_reg > CFG_W'(CAP)) ? CFG_W'(CAP) : cluster_count_reg;
    assign accept   = in_valid && in_ready;
    assign lab_ext  = LA_W'(label[IDX_W-1:0]);
    assign pix_addr = lab_ext[AW-1:0];
    assign pix_ok   = !label[LABEL_W-1]
                   && (CFG_W'(label[IDX_W-1:0]) < used)
                   && (CRD_W'(x_pos) < CRD_W'(MAX_DIM))
                   && (CRD_W'(y_pos) < CRD_W'(MAX_DIM));

    // readout index helpers
    assign idx_cmp      = CMP_W'(idx_reg);
    assign in_use       = idx_cmp < CMP_W'(used);
    assign is_last_used = CMP_W'(idx_cmp + CMP_W'(1)) == CMP_W'(used);
    assign idx_last     = idx_reg == AW'(MAX_CLUSTERS - 1);
    assign idx_ext      = LA_W'(idx_reg);

    // read-modify-write: forward last write on same-entry hit
    assign old_ent = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign cnt_sum = {1'b0, old_ent.cnt} + (CNT_W + 1)'(1);
    assign sx_sum  = {1'b0, old_ent.sum_x} + (SUM_W + 1)'(s1_x_reg);
    assign sy_sum  = {1'b0, old_ent.sum_y} + (SUM_W + 1)'(s1_y_reg);
    assign acc_wr  = s1_vld_reg && !cnt_sum[CNT_W] && !sx_sum[SUM_W] && !sy_sum[SUM_W];

    assign new_ent.cnt   = cnt_sum[CNT_W-1:0];
    assign new_ent.sum_x = sx_sum[SUM_W-1:0];
    assign new_ent.sum_y = sy_sum[SUM_W-1:0];

    // RAM port muxing
    assign clr_wr  = (state_reg == ST_CLEAR) || (state_reg == ST_LOOK);
    assign wr_en   = acc_wr || clr_wr;
    assign wr_addr = acc_wr ? s1_addr_reg : idx_reg;
    assign wr_data = acc_wr ? new_ent : '0;
    assign rd_en   = accept || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_RUN) ? pix_addr : idx_reg;

    lcacc_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign div_start = (state_reg == ST_LOOK) && in_use && (rd_data.cnt != '0);

    lcacc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_x (rd_data.sum_x),
        .dividend_y (rd_data.sum_y),
        .divisor    (rd_data.cnt),
        .res        (div_res)
    );

    // readout sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        load_x         = div_res.quo_x;
        load_y         = div_res.quo_y;
        load_empty     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_RUN:
            begin
                if (accept && last_pixel)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                idx_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (!in_use)
                begin
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
                else if (rd_data.cnt == '0)
                begin
                    out_load       = 1'b1;
                    load_x         = '0;
                    load_y         = '0;
                    load_empty     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            idx_reg           <= '0;
            cluster_count_reg <= CFG_RESET;
            s1_vld_reg        <= 1'b0;
            fwd_hit_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            s1_vld_reg    <= accept && pix_ok;
            fwd_hit_reg   <= wr_en && rd_en && (wr_addr == rd_addr);
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cluster_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= pix_addr;
            s1_x_reg    <= x_pos;
            s1_y_reg    <= y_pos;
        end
        fwd_data_reg <= wr_data;
        if (out_load)
        begin
            cluster_index_reg <= idx_ext[IDX_W-1:0];
            center_x_reg      <= load_x;
            center_y_reg      <= load_y;
            empty_res_reg     <= load_empty;
            last_reg          <= is_last_used;
        end
    end

    assign in_ready      = state_reg == ST_RUN;
    assign out_valid     = out_valid_reg;
    assign cluster_index = cluster_index_reg;
    assign center_x      = center_x_reg;
    assign center_y      = center_y_reg;
    assign empty_res     = empty_res_reg;
    assign last          = last_reg;

    `LCA_ASSERT_IMPL(a_in_out_excl, clk, rst_n, in_ready, !out_valid_reg, "input open during readout")
    `LCA_ASSERT_NEXT(a_last_stops_in, clk, rst_n, accept && last_pixel, !in_ready, "input open after last pixel")
    `LCA_ASSERT_IMPL(a_out_in_use, clk, rst_n, out_valid_reg, in_use, "result for cluster not in use")
    `LCA_ASSERT_IMPL(a_acc_wr_phase, clk, rst_n, acc_wr, state_reg == ST_RUN || state_reg == ST_DRAIN, "pixel update outside accumulate phase")

endmodule

### hdl/lcacc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read; a read of the address
// written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module lcacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/lcacc_div.sv
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring divider, one quotient bit per cycle, dividing both sums by the
// shared pixel count in parallel. The quotient is known to fit 12 bits.
// ----------------------------------------------------------------------------
module lcacc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcacc_pkg::SUM_W-1:0] dividend_x,
    input  logic [lcacc_pkg::SUM_W-1:0] dividend_y,
    input  logic [lcacc_pkg::CNT_W-1:0] divisor,
    output lcacc_pkg::div_res_t         res
);

    import lcacc_pkg::*;
    `include "label_centroid_accumulator_unit_defines.svh"

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rx_reg, rx_next;
    logic [SUM_W-1:0]  ry_reg, ry_next;
    logic [SUM_W-1:0]  d_reg, d_next;
    logic [QUO_W-1:0]  qx_reg, qx_next;
    logic [QUO_W-1:0]  qy_reg, qy_next;
    logic              ge_x, ge_y;
    logic              step_last;

    assign ge_x      = rx_reg >= d_reg;
    assign ge_y      = ry_reg >= d_reg;
    assign step_last = step_reg == STEP_W'(QUO_W - 1);

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (step_last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath: trial subtract, shift divisor right
    always_comb
    begin
        rx_next = rx_reg;
        ry_next = ry_reg;
        d_next  = d_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        if (start)
        begin
            rx_next = dividend_x;
            ry_next = dividend_y;
            d_next  = {divisor, {DIV_SHIFT{1'b0}}};
            qx_next = '0;
            qy_next = '0;
        end
        else if (busy_reg)
        begin
            rx_next = ge_x ? (rx_reg - d_reg) : rx_reg;
            ry_next = ge_y ? (ry_reg - d_reg) : ry_reg;
            qx_next = {qx_reg[QUO_W-2:0], ge_x};
            qy_next = {qy_reg[QUO_W-2:0], ge_y};
            d_next  = d_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        d_reg  <= d_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
    end

    assign res.busy  = busy_reg;
    assign res.done  = done_reg;
    assign res.quo_x = qx_reg;
    assign res.quo_y = qy_reg;

    `LCA_ASSERT_IMPL(a_div_no_restart, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `LCA_ASSERT_NEXT(a_div_done_idle, clk, rst_n, done_reg, !busy_reg, "divider busy after done")
    `LCA_ASSERT_IMPL(a_div_done_excl, clk, rst_n, done_reg, !busy_reg, "divider done while busy")

endmodule

### tb/centroid_check_pkg.sv
// ----------------------------------------------------------------------------
// Centroid tracker for the label centroid accumulator testbench
// Keeps its own per-cluster pixel counts and coordinate sums, works out the
// centroid words each image readout should produce, and checks the words
// that the block delivers against them in order.
// ----------------------------------------------------------------------------
package centroid_check_pkg;

    import lcacc_pkg::*;

    // one expected readout word
    typedef struct {
        logic [IDX_W-1:0]   cluster_index;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               empty_res;
        logic               last;
    } centroid_t;

    class centroid_tracker;

        logic [CFG_W-1:0] cluster_count;
        logic [CNT_W-1:0] pixel_total [MAX_CLUSTERS_DEF];
        logic [SUM_W-1:0] x_total     [MAX_CLUSTERS_DEF];
        logic [SUM_W-1:0] y_total     [MAX_CLUSTERS_DEF];
        centroid_t        pending_centroids [$];
        int               errors;

        function new();
            cluster_count = CFG_RESET;
            errors        = 0;
            clear_totals();
        endfunction

        function void clear_totals();
            for (int i = 0; i < MAX_CLUSTERS_DEF; i++)
            begin
                pixel_total[i] = '0;
                x_total[i]     = '0;
                y_total[i]     = '0;
            end
        endfunction

        // register value clipped to the number of clusters the block holds
        function int clusters_used();
            return (cluster_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF
                                                      : int'(cluster_count);
        endfunction

        function int pending();
            return pending_centroids.size();
        endfunction

        // accumulate one accepted pixel word; on the last pixel queue readout
        function void add_pixel(logic signed [LABEL_W-1:0] lab,
                                logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic fin);
            int               used;
            int               k;
            centroid_t        c;
            logic [SUM_W-1:0] mean;
            used = clusters_used();
            // negative, out-of-use labels and off-image coordinates add nothing
            if (!lab[LABEL_W-1] && int'(lab) < used &&
                x < MAX_DIM_DEF && y < MAX_DIM_DEF)
            begin
                k = int'(lab);
                // drop a pixel that would overflow its cluster's accumulators
                if (pixel_total[k] < {CNT_W{1'b1}} &&
                    x_total[k] <= {SUM_W{1'b1}} - SUM_W'(x) &&
                    y_total[k] <= {SUM_W{1'b1}} - SUM_W'(y))
                begin
                    pixel_total[k] = pixel_total[k] + 1'b1;
                    x_total[k]     = x_total[k] + SUM_W'(x);
                    y_total[k]     = y_total[k] + SUM_W'(y);
                end
            end
            if (!fin)
                return;
            // readout in index order, then clear everything
            for (int i = 0; i < used; i++)
            begin
                c.cluster_index = IDX_W'(i);
                c.last          = (i + 1 == used);
                if (pixel_total[i] == '0)
                begin
                    c.center_x  = '0;
                    c.center_y  = '0;
                    c.empty_res = 1'b1;
                end
                else
                begin
                    mean        = x_total[i] / SUM_W'(pixel_total[i]);
                    c.center_x  = mean[COORD_W-1:0];
                    mean        = y_total[i] / SUM_W'(pixel_total[i]);
                    c.center_y  = mean[COORD_W-1:0];
                    c.empty_res = 1'b0;
                end
                pending_centroids.push_back(c);
            end
            clear_totals();
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_centroid(logic [IDX_W-1:0] idx,
                                     logic [COORD_W-1:0] cx,
                                     logic [COORD_W-1:0] cy,
                                     logic emp, logic lst);
            centroid_t e;
            if (pending_centroids.size() == 0)
            begin
                $error("centroid word for cluster %0d with none expected", idx);
                errors++;
                return;
            end
            e = pending_centroids.pop_front();
            if (idx !== e.cluster_index)
            begin
                $error("cluster_index: expected %0d, got %0d", e.cluster_index, idx);
                errors++;
            end
            if (cx !== e.center_x)
            begin
                $error("center_x: expected %0d, got %0d", e.center_x, cx);
                errors++;
            end
            if (cy !== e.center_y)
            begin
                $error("center_y: expected %0d, got %0d", e.center_y, cy);
                errors++;
            end
            if (emp !== e.empty_res)
            begin
                $error("empty_res: expected %0d, got %0d", e.empty_res, emp);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, lst);
                errors++;
            end
        endfunction

    endclass

endpackage

### tb/tb_label_centroid_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Testbench for label_centroid_accumulator_unit
// Streams labelled pixel images through the block under several cluster
// counts, with random idle cycles on both channels, a long output hold-off
// and drain pauses, and checks every centroid word against a tracker model.
// ----------------------------------------------------------------------------
module tb_label_centroid_accumulator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import lcacc_pkg::*;
    import centroid_check_pkg::*;

    localparam int MAX_GAP        = 11;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 350;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [CFG_W-1:0]            cfg_wr_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [LABEL_W-1:0]   label;
    logic [COORD_W-1:0]          x_pos;
    logic [COORD_W-1:0]          y_pos;
    logic                        last_pixel;
    logic                        out_valid;
    logic                        out_ready;
    logic [IDX_W-1:0]            cluster_index;
    logic [COORD_W-1:0]          center_x;
    logic [COORD_W-1:0]          center_y;
    logic                        empty_res;
    logic                        last;

    centroid_tracker tracker;
    bit              sender_idle;
    bit              receiver_idle;
    bit              hold_off_req;
    int              random_sent;
    int              stall_cycles;

    label_centroid_accumulator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .label         (label),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .last_pixel    (last_pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cluster_index (cluster_index),
        .center_x      (center_x),
        .center_y      (center_y),
        .empty_res     (empty_res),
        .last          (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one pixel word and wait for it to be taken
    task automatic send_pixel(input logic signed [LABEL_W-1:0] lab,
                              input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y,
                              input logic fin);
        int gap;
        gap = sender_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        label      <= lab;
        x_pos      <= x;
        y_pos      <= y;
        last_pixel <= fin;
        do @(posedge clk); while (!in_ready);
        tracker.add_pixel(lab, x, y, fin);
    endtask

    // stop offering, let all centroids arrive, then let the clear walk finish
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic set_cluster_count(input logic [CFG_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.cluster_count = value;
    endtask

    // coordinate biased toward the image edges
    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? {COORD_W{1'b1}} : {COORD_W{1'b0}};
        return COORD_W'($urandom_range(0, MAX_DIM_DEF - 1));
    endfunction

    // one image of random pixels, last one marked
    task automatic send_random_image(input int len);
        int                        used;
        int                        r;
        logic signed [LABEL_W-1:0] lab;
        used = tracker.clusters_used();
        for (int n = 0; n < len; n++)
        begin
            r = $urandom_range(0, 9);
            if (used > 0 && r < 4)
                lab = LABEL_W'($urandom_range(0, used - 1));
            else if (used > 0 && r < 7)
                lab = LABEL_W'($urandom_range(0, ((used < 4) ? used : 4) - 1));
            else if (r < 9)
                lab = LABEL_W'(7'h40 | $urandom_range(0, 63));
            else
                lab = LABEL_W'($urandom_range(0, 127));
            send_pixel(lab, pick_coord(), pick_coord(), n == len - 1);
            random_sent++;
        end
    endtask

    // stimulus
    initial
    begin
        int               images;
        int               len;
        int               r;
        bit               first;
        logic [CFG_W-1:0] cfg;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        label         = '0;
        x_pos         = '0;
        y_pos         = '0;
        last_pixel    = 1'b0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_off_req  = 1'b0;
        random_sent   = 0;
        tracker       = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // corners with the reset cluster count, negative labels skipped
        send_pixel(0, 0, 0, 1'b0);
        send_pixel(0, 4095, 4095, 1'b0);
        send_pixel(63, 4095, 0, 1'b0);
        send_pixel(63, 0, 4095, 1'b0);
        send_pixel(-1, 123, 456, 1'b0);
        send_pixel(-64, 4095, 4095, 1'b0);
        send_pixel(5, 1, 2, 1'b0);
        send_pixel(5, 2, 2, 1'b0);
        send_pixel(5, 4, 3, 1'b1);
        // unlabelled pixel still triggers readout
        send_pixel(-1, 7, 7, 1'b1);

        // labels at or above the count are ignored
        set_cluster_count(8);
        send_pixel(10, 100, 100, 1'b0);
        send_pixel(63, 1, 1, 1'b0);
        send_pixel(7, 4095, 4095, 1'b0);
        send_pixel(3, 10, 20, 1'b1);

        // zero count: no words, accumulators still cleared
        set_cluster_count(0);
        send_pixel(0, 5, 5, 1'b0);
        send_pixel(0, 5, 5, 1'b1);
        set_cluster_count(1);
        send_pixel(0, 9, 9, 1'b1);

        // register above the cluster capacity
        set_cluster_count(CFG_W'(CFG_MAX));
        send_pixel(63, 100, 200, 1'b0);
        send_pixel(63, 101, 201, 1'b1);

        // random images under random counts
        first = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (first || r == 3)
                cfg = CFG_W'(MAX_CLUSTERS_DEF);
            else if (r == 0)
                cfg = 0;
            else if (r == 1)
                cfg = CFG_W'($urandom_range(MAX_CLUSTERS_DEF + 1, CFG_MAX));
            else if (r == 2)
                cfg = 1;
            else
                cfg = CFG_W'($urandom_range(2, MAX_CLUSTERS_DEF - 1));
            set_cluster_count(cfg);
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            images = first ? 3 : $urandom_range(1, 3);
            for (int k = 0; k < images; k++)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
                send_random_image(len);
                // stall the output while the next image is offered
                if (first && k == 0)
                    hold_off_req = 1'b1;
            end
            first = 1'b0;
        end

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random ready gaps, one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = receiver_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap += HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            tracker.check_centroid(cluster_index, center_x, center_y, empty_res, last);
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
